// File: rtl/stxlrc_pkg.sv
// Shared types and constants for the STX/ETX/LRC frame receiver.
`timescale 1ns / 1ps

package stxlrc_pkg;

  // Framing characters and reply bytes
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_BAR = 8'h7C;

  // Reset value of the idle timeout register
  localparam logic [15:0] TIMEOUT_RESET = 16'd350;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Input word function codes
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_LRC  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_FEND    = 3'd1,
    KIND_ACCEPT  = 3'd2,
    KIND_REJECT  = 3'd3,
    KIND_RESTART = 3'd4
  } out_kind_e;

  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_STX   = 2'd1,
    CLS_ETX   = 2'd2,
    CLS_BAR   = 2'd3
  } byte_class_e;

  // One classified word as it travels from front to back
  typedef struct packed {
    logic        is_tick;
    byte_class_e cls;
    logic [7:0]  data;
  } item_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/stxlrc_front.sv
// Front end: takes input words and classifies them for the queue.
`timescale 1ns / 1ps

module stxlrc_front (
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   func_i,
  input  logic [7:0]             rx_byte_i,
  input  stxlrc_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output stxlrc_pkg::item_t      push_item_o
);
  import stxlrc_pkg::*;

  // Stall while the queue has no free slot
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;

  // Decode the special characters once, here
  always_comb begin
    push_item_o.is_tick = (func_i == FUNC_TICK);
    push_item_o.data    = rx_byte_i;
    case (rx_byte_i)
      CH_STX:  push_item_o.cls = CLS_STX;
      CH_ETX:  push_item_o.cls = CLS_ETX;
      CH_BAR:  push_item_o.cls = CLS_BAR;
      default: push_item_o.cls = CLS_OTHER;
    endcase
  end

endmodule

// File: rtl/stxlrc_queue.sv
// Short word queue between the front and the back.
`timescale 1ns / 1ps

module stxlrc_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  stxlrc_pkg::item_t         push_item_i,
  input  logic                      pop_i,
  output stxlrc_pkg::item_t         pop_item_o,
  output stxlrc_pkg::queue_status_t status_o
);
  import stxlrc_pkg::*;

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;

  assign status_o.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign pop_item_o     = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// File: rtl/stxlrc_back.sv
// Back end: frame state machine, LRC check, timeout and output register.
`timescale 1ns / 1ps

module stxlrc_back #(
  parameter int unsigned MAX_FIELDS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              q_empty_i,
  input  stxlrc_pkg::item_t q_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        out_kind_o,
  output logic [7:0]        out_byte_o,
  output logic [3:0]        field_number_o
);
  import stxlrc_pkg::*;

  // Field index saturates at the lesser of MAX_FIELDS-1 and 15
  localparam int unsigned FieldLimitInt = (MAX_FIELDS - 1 > 15) ? 15 : MAX_FIELDS - 1;
  localparam logic [3:0]  FieldLimit    = 4'(FieldLimitInt);

  phase_e      phase_q, phase_d;
  logic [7:0]  acc_q, acc_d;
  logic [15:0] idle_cnt_q, idle_cnt_d;
  logic [3:0]  field_q, field_d;
  logic [15:0] timeout_q;

  logic        out_valid_q, out_valid_d;
  out_kind_e   out_kind_q, res_kind;
  logic [7:0]  out_byte_q, res_byte;
  logic [3:0]  out_field_q, res_field;
  logic        emit;

  logic        out_taken;
  logic [15:0] idle_inc;
  logic [7:0]  acc_x;

  assign out_taken = out_valid_q & ~out_stall_i;
  // Take a word when the output register is free or being emptied
  assign pop_o     = ~q_empty_i & (~out_valid_q | ~out_stall_i);

  assign idle_inc = (idle_cnt_q != 16'hFFFF) ? idle_cnt_q + 16'd1 : idle_cnt_q;
  assign acc_x    = acc_q ^ q_item_i.data;

  // Next state and result for the word at the head of the queue
  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    idle_cnt_d = idle_cnt_q;
    field_d    = field_q;
    emit       = 1'b0;
    res_kind   = KIND_CHAR;
    res_byte   = q_item_i.data;
    res_field  = field_q;
    if (pop_o) begin
      if (q_item_i.is_tick) begin
        // Idle timeout; a zero limit disables it
        if (timeout_q != '0) begin
          idle_cnt_d = idle_inc;
          if (idle_inc >= timeout_q) begin
            idle_cnt_d = '0;
            phase_d    = PH_IDLE;
            field_d    = '0;
            emit       = 1'b1;
            res_kind   = KIND_REJECT;
            res_byte   = CH_NAK;
          end
        end
      end else begin
        idle_cnt_d = '0;
        case (phase_q)
          PH_LRC: begin
            acc_d    = acc_x;
            phase_d  = PH_IDLE;
            field_d  = '0;
            emit     = 1'b1;
            res_kind = (acc_x == '0) ? KIND_ACCEPT : KIND_REJECT;
            res_byte = (acc_x == '0) ? CH_ACK : CH_NAK;
          end
          PH_DATA: begin
            if (q_item_i.cls == CLS_STX) begin
              // Restart drops the partial frame
              acc_d     = '0;
              field_d   = '0;
              emit      = 1'b1;
              res_kind  = KIND_RESTART;
              res_byte  = CH_STX;
              res_field = '0;
            end else begin
              acc_d = acc_x;
              emit  = 1'b1;
              case (q_item_i.cls)
                CLS_ETX: begin
                  phase_d  = PH_LRC;
                  res_kind = KIND_FEND;
                end
                CLS_BAR: begin
                  res_kind = KIND_FEND;
                  if (field_q < FieldLimit) begin
                    field_d = field_q + 4'd1;
                  end
                end
                default: res_kind = KIND_CHAR;
              endcase
            end
          end
          default: begin
            // Idle: only an STX opens a frame
            if (q_item_i.cls == CLS_STX) begin
              phase_d = PH_DATA;
              acc_d   = '0;
              field_d = '0;
            end else begin
              phase_d = PH_IDLE;
              acc_d   = acc_x;
            end
          end
        endcase
      end
    end
  end

  // Output register valid
  always_comb begin
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_taken) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      idle_cnt_q  <= '0;
      field_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      idle_cnt_q  <= idle_cnt_d;
      field_q     <= field_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_kind_q  <= res_kind;
      out_byte_q  <= res_byte;
      out_field_q <= res_field;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_byte_o     = out_byte_q;
  assign field_number_o = out_field_q;

  // A verdict always leaves the frame idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && emit && (res_kind == KIND_ACCEPT || res_kind == KIND_REJECT))
      |=> (phase_q == PH_IDLE && field_q == '0))
    else $error("verdict did not return to idle");

  // Reply byte is ACK when the verdict is accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KIND_ACCEPT) |-> (out_byte_o == CH_ACK))
    else $error("accept without ACK");

  // Field index never passes the saturation limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_q <= FieldLimit)
    else $error("field index beyond limit");

  // A waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("pop while result stalled");

endmodule

// File: rtl/stx_etx_lrc_frame_receiver_unit.sv
// Top level of the STX/ETX/LRC frame receiver.
`timescale 1ns / 1ps

// Usage
//   Input channel: in_valid_i / in_stall_o with func_i (0 byte, 1 tick) and
//   rx_byte_i. Output channel: out_valid_o / out_stall_i with out_kind_o,
//   out_byte_o and field_number_o. A word moves when valid is high and stall
//   is low. cfg_we_i writes cfg_wdata_i into the idle timeout (ticks, zero
//   disables); write it only while the block is idle.
// Data path and throughput
//   The front classifies each input word and puts it in a two-entry queue.
//   The back takes one word per cycle from the queue while the output
//   register is free or being emptied, runs the frame state machine and
//   loads the output register, so a result is valid in the cycle after
//   its input word is taken. One word per cycle is sustained while the output
//   is not stalled; words that give no result are still taken at that rate.
// Reset and stall
//   Reset empties the queue and output register, puts the frame logic in
//   idle and sets the timeout to 350 ticks. While the receiver stalls, the
//   result is held, the back stops and the queue fills; then in_stall_o rises.

module stx_etx_lrc_frame_receiver_unit #(
  parameter int unsigned MAX_FIELDS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_kind_o,
  output logic [7:0]  out_byte_o,
  output logic [3:0]  field_number_o
);
  import stxlrc_pkg::*;

  queue_status_t q_status;
  item_t         push_item;
  item_t         pop_item;
  logic          push;
  logic          pop;

  stxlrc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_item_o (push_item)
  );

  stxlrc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .status_o    (q_status)
  );

  stxlrc_back #(
    .MAX_FIELDS (MAX_FIELDS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_empty_i      (q_status.empty),
    .q_item_i       (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_byte_o     (out_byte_o),
    .field_number_o (field_number_o)
  );

endmodule
